FILE: hw/rtl/hsom_pkg.sv
package hsom_pkg;

    // Operation codes
    typedef enum logic [1:0] {
        OP_HIT    = 2'd0,
        OP_EVENT  = 2'd1,
        OP_FINISH = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Hit status codes
    localparam logic [1:0] ST_UNMASKED = 2'd0;
    localparam logic [1:0] ST_MASKED   = 2'd1;
    localparam logic [1:0] ST_BELOW    = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_OCC     = 3'd0;
    localparam logic [2:0] REG_EVENTS_MASK = 3'd1;
    localparam logic [2:0] REG_THRESH_U    = 3'd2;
    localparam logic [2:0] REG_THRESH_V    = 3'd3;
    localparam logic [2:0] REG_STRIPS_U    = 3'd4;
    localparam logic [2:0] REG_STRIPS_V    = 3'd5;
    localparam logic [2:0] REG_SENSORS     = 3'd6;

    localparam int CFG_W     = 24;
    localparam int EVT_W     = 24;
    localparam int EV16_W    = 16;
    localparam int LIMIT_W   = 44;
    localparam int MAX_REPORTS = 8;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         sensor;
        logic               side_is_u;
        logic signed [11:0] strip;
        logic signed [15:0] signal;
    } in_t;

    typedef struct packed {
        logic [1:0]  hit_status;
        logic        strip_masked;
        logic [23:0] hit_count;
        logic [2:0]  report_sensor;
        logic [15:0] digits_u;
        logic [15:0] digits_v;
        logic [15:0] good_u;
        logic [15:0] good_v;
        logic        good_valid;
        logic        last;
    } out_t;

    // Per-event counter control
    typedef struct packed {
        logic       inc_digit;
        logic       inc_good;
        logic       is_u;
        logic [2:0] sensor;
        logic       clear;
    } evt_ctl_t;

    // Per-event counter read data
    typedef struct packed {
        logic [15:0] digits_u;
        logic [15:0] digits_v;
        logic [15:0] good_u;
        logic [15:0] good_v;
    } evt_rd_t;

endpackage

FILE: hw/rtl/hot_strip_occupancy_masker_core.sv
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid / in_stall   | in_data (op, sensor, side, strip, signal)
// out     | output    | out_valid / out_stall | out_data (status, count, event report)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// A hit or read is accepted, decoded with its RAM read, then written back with its
// result; one turned away by sensor, threshold or strip range gives it at decode.
// End of event emits one report per sensor in use, plus a mask walk if due; a
// finish runs the walk, then emits a closing beat. Mask walk: a read step and a
// write step per strip slot over sensors_in_use * MAX_STRIPS slots, with both
// compares sharing the RAM read port. After reset a clearing pass over all
// NUM_SENSORS * MAX_STRIPS slots zeroes the counter RAMs; no beat is accepted
// until it ends. Output stalls hold the sequencer in the state that wants to emit.
module hot_strip_occupancy_masker_core #(
    parameter int NUM_SENSORS = 8,
    parameter int MAX_STRIPS  = 1024,
    parameter int COUNT_BITS  = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  hsom_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output hsom_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [23:0]     cfg_data
);

    import hsom_pkg::*;

    localparam int DEPTH   = NUM_SENSORS * MAX_STRIPS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COL_W   = $clog2(MAX_STRIPS);
    localparam int REPORTS = NUM_SENSORS < MAX_REPORTS ? NUM_SENSORS : MAX_REPORTS;
    localparam int RAM_W   = COUNT_BITS + 1;
    localparam int CMP_W   = (COUNT_BITS + 16) > LIMIT_W ? (COUNT_BITS + 16) : LIMIT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_EXEC    = 10'b0000000100,
        S_RMW     = 10'b0000001000,
        S_REPORT  = 10'b0000010000,
        S_EVT_END = 10'b0000100000,
        S_LIMIT   = 10'b0001000000,
        S_WALK_RD = 10'b0010000000,
        S_WALK_WR = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    // Configuration registers
    logic [19:0]        max_occ_reg;
    logic [EVT_W-1:0]   events_mask_reg;
    logic signed [15:0] thr_u_reg;
    logic signed [15:0] thr_v_reg;
    logic [10:0]        strips_u_reg;
    logic [10:0]        strips_v_reg;
    logic [3:0]         sensors_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_occ_reg     <= 20'd32768;
            events_mask_reg <= 24'd20000;
            thr_u_reg       <= '0;
            thr_v_reg       <= '0;
            strips_u_reg    <= 11'd1024;
            strips_v_reg    <= 11'd1024;
            sensors_reg     <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_OCC:     max_occ_reg     <= cfg_data[19:0];
                REG_EVENTS_MASK: events_mask_reg <= cfg_data;
                REG_THRESH_U:    thr_u_reg       <= cfg_data[15:0];
                REG_THRESH_V:    thr_v_reg       <= cfg_data[15:0];
                REG_STRIPS_U:    strips_u_reg    <= cfg_data[10:0];
                REG_STRIPS_V:    strips_v_reg    <= cfg_data[10:0];
                REG_SENSORS:     sensors_reg     <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Active counts
    logic [3:0]  ns;
    logic [12:0] lim_u;
    logic [12:0] lim_v;

    assign ns    = (sensors_reg > 4'(REPORTS)) ? 4'(REPORTS) : sensors_reg;
    assign lim_u = (13'(strips_u_reg) > 13'(MAX_STRIPS)) ? 13'(MAX_STRIPS) : 13'(strips_u_reg);
    assign lim_v = (13'(strips_v_reg) > 13'(MAX_STRIPS)) ? 13'(MAX_STRIPS) : 13'(strips_v_reg);

    // Sequencer registers
    state_t              state_reg, state_next;
    in_t                 item_reg, item_next;
    logic [3:0]          rpt_reg, rpt_next;
    logic [ADDR_W-1:0]   walk_addr_reg, walk_addr_next;
    logic [COL_W-1:0]    walk_col_reg, walk_col_next;
    logic [3:0]          walk_sen_reg, walk_sen_next;
    logic                walk_fin_reg, walk_fin_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [EVT_W-1:0]    evt_total_reg, evt_total_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;

    // Item decode
    logic              is_u;
    logic              sens_ok;
    logic              in_range;
    logic              below;
    logic [12:0]       strip_lim;
    logic [ADDR_W-1:0] item_addr;
    logic              out_free;

    assign is_u      = item_reg.side_is_u;
    assign sens_ok   = {1'b0, item_reg.sensor} < ns;
    assign strip_lim = is_u ? lim_u : lim_v;
    assign in_range  = !item_reg.strip[11] && ({1'b0, item_reg.strip} < strip_lim);
    assign below     = item_reg.signal < (is_u ? thr_u_reg : thr_v_reg);
    assign item_addr = ADDR_W'(item_reg.sensor * MAX_STRIPS)
                     + ADDR_W'($unsigned(item_reg.strip));
    assign out_free  = !out_valid_reg || !out_stall;

    // Counter RAMs: {mask, count}
    logic              we_u, we_v;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [RAM_W-1:0]  wd_u, wd_v, rd_u, rd_v;

    hsom_ram #(.WIDTH(RAM_W), .DEPTH(DEPTH)) u_ram_u (
        .clk     (clk),
        .we      (we_u),
        .wr_addr (wr_addr),
        .wr_data (wd_u),
        .rd_addr (rd_addr),
        .rd_data (rd_u)
    );

    hsom_ram #(.WIDTH(RAM_W), .DEPTH(DEPTH)) u_ram_v (
        .clk     (clk),
        .we      (we_v),
        .wr_addr (wr_addr),
        .wr_data (wd_v),
        .rd_addr (rd_addr),
        .rd_data (rd_v)
    );

    // Read-modify-write view of the addressed strip
    logic [RAM_W-1:0]      rd_sel;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  msk;

    assign rd_sel  = is_u ? rd_u : rd_v;
    assign cnt     = rd_sel[COUNT_BITS-1:0];
    assign msk     = rd_sel[COUNT_BITS];
    assign cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;

    // Shared occupancy compare for the mask walk
    logic cmp_u, cmp_v, col_u_ok, col_v_ok;

    assign cmp_u    = (CMP_W'(rd_u[COUNT_BITS-1:0]) << 16) > CMP_W'(limit_reg);
    assign cmp_v    = (CMP_W'(rd_v[COUNT_BITS-1:0]) << 16) > CMP_W'(limit_reg);
    assign col_u_ok = 13'(walk_col_reg) < lim_u;
    assign col_v_ok = 13'(walk_col_reg) < lim_v;

    // Per-event counters
    evt_ctl_t evt_ctl;
    evt_rd_t  evt_rd;

    hsom_evt_cnt #(.REPORTS(REPORTS)) u_evt (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (evt_ctl),
        .rd_idx (rpt_reg[2:0]),
        .rd     (evt_rd)
    );

    logic [EVT_W-1:0] evt_inc;
    assign evt_inc = (evt_total_reg == {EVT_W{1'b1}}) ? evt_total_reg : evt_total_reg + 1'b1;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        rpt_next       = rpt_reg;
        walk_addr_next = walk_addr_reg;
        walk_col_next  = walk_col_reg;
        walk_sen_next  = walk_sen_reg;
        walk_fin_next  = walk_fin_reg;
        limit_next     = limit_reg;
        clr_addr_next  = clr_addr_reg;
        evt_total_next = evt_total_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        in_stall       = 1'b1;
        we_u           = 1'b0;
        we_v           = 1'b0;
        wr_addr        = item_addr;
        wd_u           = {msk, cnt_inc};
        wd_v           = {msk, cnt_inc};
        rd_addr        = item_addr;
        evt_ctl        = '{inc_digit: 1'b0, inc_good: 1'b0, is_u: is_u,
                           sensor: item_reg.sensor, clear: 1'b0};

        unique case (state_reg)
            S_CLEAR:
            begin
                we_u    = 1'b1;
                we_v    = 1'b1;
                wr_addr = clr_addr_reg;
                wd_u    = '0;
                wd_v    = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                priority if (item_reg.operation == OP_EVENT)
                begin
                    rpt_next   = '0;
                    state_next = (ns == '0) ? S_EVT_END : S_REPORT;
                end
                else if (item_reg.operation == OP_FINISH)
                begin
                    walk_fin_next = 1'b1;
                    state_next    = S_LIMIT;
                end
                else if (out_free)
                begin
                    out_data_next      = '0;
                    out_data_next.last = 1'b1;
                    priority if (!sens_ok)
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next.hit_status = ST_RANGE;
                        state_next               = S_IDLE;
                    end
                    else if (item_reg.operation == OP_HIT && below)
                    begin
                        evt_ctl.inc_digit        = 1'b1;
                        out_valid_next           = 1'b1;
                        out_data_next.hit_status = ST_BELOW;
                        state_next               = S_IDLE;
                    end
                    else if (!in_range)
                    begin
                        evt_ctl.inc_digit        = (item_reg.operation == OP_HIT);
                        out_valid_next           = 1'b1;
                        out_data_next.hit_status = ST_RANGE;
                        state_next               = S_IDLE;
                    end
                    else
                    begin
                        evt_ctl.inc_digit = (item_reg.operation == OP_HIT);
                        state_next        = S_RMW;
                    end
                end
            end

            S_RMW:
            begin
                // Output is free here: EXEC only leaves for RMW when it was
                out_valid_next             = 1'b1;
                out_data_next              = '0;
                out_data_next.last         = 1'b1;
                out_data_next.hit_status   = msk ? ST_MASKED : ST_UNMASKED;
                out_data_next.strip_masked = msk;
                if (item_reg.operation == OP_HIT)
                begin
                    we_u                    = is_u;
                    we_v                    = !is_u;
                    evt_ctl.inc_good        = !msk;
                    out_data_next.hit_count = 24'(cnt_inc);
                end
                else
                begin
                    out_data_next.hit_count = 24'(cnt);
                end
                state_next = S_IDLE;
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next               = '0;
                    out_data_next.report_sensor = rpt_reg[2:0];
                    out_data_next.digits_u      = evt_rd.digits_u;
                    out_data_next.digits_v      = evt_rd.digits_v;
                    out_data_next.good_u        = evt_rd.good_u;
                    out_data_next.good_v        = evt_rd.good_v;
                    out_data_next.good_valid    = evt_total_reg > events_mask_reg;
                    out_data_next.last          = (rpt_reg + 1'b1 == ns);
                    rpt_next                    = rpt_reg + 1'b1;
                    if (rpt_reg + 1'b1 == ns)
                    begin
                        state_next = S_EVT_END;
                    end
                end
            end

            S_EVT_END:
            begin
                evt_ctl.clear  = 1'b1;
                evt_total_next = evt_inc;
                walk_fin_next  = 1'b0;
                state_next     = (evt_inc == events_mask_reg) ? S_LIMIT : S_IDLE;
            end

            S_LIMIT:
            begin
                limit_next     = LIMIT_W'(max_occ_reg) * LIMIT_W'(evt_total_reg);
                walk_addr_next = '0;
                walk_col_next  = '0;
                walk_sen_next  = '0;
                if (ns == '0)
                begin
                    state_next = walk_fin_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                rd_addr    = walk_addr_reg;
                state_next = S_WALK_WR;
            end

            S_WALK_WR:
            begin
                rd_addr        = walk_addr_reg;
                wr_addr        = walk_addr_reg;
                we_u           = col_u_ok && cmp_u;
                we_v           = col_v_ok && cmp_v;
                wd_u           = {1'b1, rd_u[COUNT_BITS-1:0]};
                wd_v           = {1'b1, rd_v[COUNT_BITS-1:0]};
                walk_addr_next = walk_addr_reg + 1'b1;
                walk_col_next  = walk_col_reg + 1'b1;
                state_next     = S_WALK_RD;
                if (walk_col_reg == COL_W'(MAX_STRIPS - 1))
                begin
                    walk_col_next = '0;
                    walk_sen_next = walk_sen_reg + 1'b1;
                    if (walk_sen_reg + 1'b1 == ns)
                    begin
                        state_next = walk_fin_reg ? S_DONE : S_IDLE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_data_next      = '0;
                    out_data_next.last = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rpt_reg       <= '0;
            walk_addr_reg <= '0;
            walk_col_reg  <= '0;
            walk_sen_reg  <= '0;
            walk_fin_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            evt_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rpt_reg       <= rpt_next;
            walk_addr_reg <= walk_addr_next;
            walk_col_reg  <= walk_col_next;
            walk_sen_reg  <= walk_sen_next;
            walk_fin_reg  <= walk_fin_next;
            clr_addr_reg  <= clr_addr_next;
            evt_total_reg <= evt_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        limit_reg    <= limit_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(we_u || we_v))
        else $error("counter RAM written while idle");

    a_rmw_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW) |-> ($past(state_reg) == S_EXEC))
        else $error("read-modify-write without decode");

    a_report_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT) |-> (rpt_reg < ns))
        else $error("report index beyond sensors in use");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_WR) |-> (walk_sen_reg < ns))
        else $error("mask walk beyond sensors in use");

endmodule

FILE: hw/rtl/hsom_ram.sv
module hsom_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 8192
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/hsom_evt_cnt.sv
module hsom_evt_cnt #(
    parameter int REPORTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hsom_pkg::evt_ctl_t ctl,
    input  logic [2:0]        rd_idx,
    output hsom_pkg::evt_rd_t  rd
);

    import hsom_pkg::*;

    localparam int IDX_W = REPORTS > 1 ? $clog2(REPORTS) : 1;

    logic [EV16_W-1:0] dig_u_reg [REPORTS];
    logic [EV16_W-1:0] dig_v_reg [REPORTS];
    logic [EV16_W-1:0] good_u_reg [REPORTS];
    logic [EV16_W-1:0] good_v_reg [REPORTS];
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_sel;

    assign wr_idx = ctl.sensor[IDX_W-1:0];
    assign rd_sel = rd_idx[IDX_W-1:0];

    function automatic logic [EV16_W-1:0] inc_sat(input logic [EV16_W-1:0] v);
        return (v == {EV16_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Saturating per-sensor counters, cleared at end of event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REPORTS; i++)
            begin
                dig_u_reg[i]  <= '0;
                dig_v_reg[i]  <= '0;
                good_u_reg[i] <= '0;
                good_v_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < REPORTS; i++)
            begin
                dig_u_reg[i]  <= '0;
                dig_v_reg[i]  <= '0;
                good_u_reg[i] <= '0;
                good_v_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.inc_digit && ctl.is_u)
            begin
                dig_u_reg[wr_idx] <= inc_sat(dig_u_reg[wr_idx]);
            end
            if (ctl.inc_digit && !ctl.is_u)
            begin
                dig_v_reg[wr_idx] <= inc_sat(dig_v_reg[wr_idx]);
            end
            if (ctl.inc_good && ctl.is_u)
            begin
                good_u_reg[wr_idx] <= inc_sat(good_u_reg[wr_idx]);
            end
            if (ctl.inc_good && !ctl.is_u)
            begin
                good_v_reg[wr_idx] <= inc_sat(good_v_reg[wr_idx]);
            end
        end
    end

    assign rd.digits_u = dig_u_reg[rd_sel];
    assign rd.digits_v = dig_v_reg[rd_sel];
    assign rd.good_u   = good_u_reg[rd_sel];
    assign rd.good_v   = good_v_reg[rd_sel];

endmodule
